@@ rtl/core/gaussian_elimination_solver_macros.svh @@
// Assertion macros for the Gaussian elimination solver.
// Used by the port checker; no other dependencies.
`ifndef GAUSSIAN_ELIMINATION_SOLVER_MACROS_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_MACROS_SVH

// Implication that must hold at every clock edge outside reset.
`define GES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define GES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ges_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Gaussian elimination solver.
// No dependencies.
`default_nettype none
package ges_pkg;
	localparam int MaxN = 16;
	localparam int DataW = 32;
	localparam int ThrW = 16;
	localparam int SizeW = 5;

	// Configuration register indexes.
	localparam logic [0:0] CfgMatrixSize = 1'b0;
	localparam logic [0:0] CfgThreshold = 1'b1;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_RD_A     = 4'd1,  // read word into register a
		OP_RD_B     = 4'd2,  // read word into register b
		OP_DIV      = 4'd3,  // start divide a / b
		OP_MUL_SUB  = 4'd4,  // acc = a - mul(c, b), write back
		OP_WR_ZERO  = 4'd5,  // write zero
		OP_WR_A     = 4'd6,  // write register a
		OP_WR_B     = 4'd7,  // write register b
		OP_CLR_S    = 4'd8,  // clear wide sum
		OP_MAC      = 4'd9,  // s += mul(a, b)
		OP_SUB_DIV  = 4'd10, // start divide sat(a - s) / b
		OP_SOL_WR   = 4'd11, // store solution
		OP_RD_X     = 4'd12  // read solution store into b
	} dp_op_t;

	// The address is wide enough for the largest supported matrix.
	typedef struct packed {
		dp_op_t      op;
		logic [12:0] addr;   // matrix address row*(MaxN+1)+col
		logic [5:0]  sidx;   // solution store index
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic a_weak;   // |a| <= threshold
		logic b_weak;   // |b| <= threshold
	} dp_status_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
		else if (v < -66'sh0_8000_0000) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [32:0] mag(input logic signed [31:0] v);
		logic signed [32:0] e;
		e = {v[31], v};
		return (v[31]) ? 33'(-e) : 33'(e);
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/ges_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ges_ram #(
	parameter int Width = 32,
	parameter int Depth = 272
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Read-first single port: a write returns the old word.
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ rtl/core/ges_div.sv @@
// Restoring divider: sat((num * 2^16) / den), truncated, one quotient bit per cycle.
// Depends on ges_pkg.
`default_nettype none
module ges_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             busy,
	output logic [31:0]      quo
);
	logic [47:0] dvd_q;
	logic [32:0] dvs_q;
	logic [48:0] rem_q;
	logic [47:0] q_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [1:0]  zmode_q; // 0 normal, 1 +max, 2 -max, 3 zero
	logic [48:0] rem_sh;
	logic [48:0] diff;
	logic [32:0] num_mag;
	logic signed [65:0] qs;

	assign num_mag = ges_pkg::mag(num);
	assign rem_sh = {rem_q[47:0], dvd_q[47]};
	assign diff = rem_sh - {16'd0, dvs_q};

	// One shift-subtract step per cycle over 48 dividend bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= (den != '0);
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag[31:0], 16'd0};
			dvs_q <= ges_pkg::mag(den);
			rem_q <= '0;
			q_q <= '0;
			neg_q <= num[31] ^ den[31];
			if (den != '0) zmode_q <= 2'd0;
			else if (num == '0) zmode_q <= 2'd3;
			else zmode_q <= num[31] ? 2'd2 : 2'd1;
		end else if (busy) begin
			dvd_q <= {dvd_q[46:0], 1'b0};
			if (!diff[48]) begin
				rem_q <= diff;
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	// Magnitude of num is at most 2^31, so 48 bits carry the full quotient.
	assign qs = neg_q ? -$signed({18'd0, q_q}) : $signed({18'd0, q_q});

	always_comb begin
		case (zmode_q)
			2'd1: quo = 32'h7FFF_FFFF;
			2'd2: quo = 32'h8000_0000;
			2'd3: quo = '0;
			default: quo = ges_pkg::sat32(qs);
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/ges_datapath.sv @@
// Datapath: matrix and solution stores, operand registers, multiplier, divider.
// Depends on ges_pkg, ges_ram, ges_div.
`default_nettype none
module ges_datapath #(
	parameter int MaxN = ges_pkg::MaxN
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ges_pkg::dp_cmd_t    cmd,
	input  wire logic                load_we,
	input  wire logic [31:0]         load_data,
	input  wire logic [15:0]         thr,
	output ges_pkg::dp_status_t      status,
	output logic [31:0]              a_val,
	output logic [31:0]              sol_val
);
	localparam int Depth = MaxN * (MaxN + 1);
	localparam int AW = $clog2(Depth);
	localparam int SW = $clog2(MaxN);

	logic [31:0] rdata, xdata, a_q, b_q, c_q, wdata, prod_q, quo, sol_wdata;
	logic signed [65:0] s_q;
	logic signed [63:0] p;
	logic        we, xwe, div_start, rd_a_q, rd_b_q, rd_x_q;
	logic        mac_pend_q;
	logic [31:0] div_num;
	ges_pkg::dp_op_t op;

	assign op = cmd.op;

	// Matrix memory.
	ges_ram #(.Width(32), .Depth(Depth)) u_mat (
		.clk(clk), .we(we), .addr(cmd.addr[AW-1:0]), .wdata(wdata), .rdata(rdata)
	);
	// Solution memory.
	ges_ram #(.Width(32), .Depth(MaxN)) u_sol (
		.clk(clk), .we(xwe), .addr(cmd.sidx[SW-1:0]), .wdata(sol_wdata), .rdata(xdata)
	);

	always_comb begin
		we = load_we;
		wdata = load_data;
		case (op)
			ges_pkg::OP_WR_ZERO: begin we = 1'b1; wdata = '0; end
			ges_pkg::OP_WR_A: begin we = 1'b1; wdata = a_q; end
			ges_pkg::OP_WR_B: begin we = 1'b1; wdata = b_q; end
			ges_pkg::OP_MUL_SUB: begin
				we = 1'b1;
				wdata = ges_pkg::sat32(66'($signed(a_q)) - 66'($signed(prod_q)));
			end
			default: ;
		endcase
	end

	// Tiny solutions are forced to zero.
	assign xwe = (op == ges_pkg::OP_SOL_WR);
	assign sol_wdata = (ges_pkg::mag(quo) <= {17'd0, thr}) ? '0 : quo;
	assign sol_val = xdata;

	assign div_start = (op == ges_pkg::OP_DIV) || (op == ges_pkg::OP_SUB_DIV);
	assign div_num = (op == ges_pkg::OP_SUB_DIV)
		? ges_pkg::sat32(66'($signed(a_q)) - s_q) : a_q;

	ges_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(b_q),
		.busy(status.div_busy), .quo(quo)
	);

	// Product of c (or a) with b, registered before use.
	assign p = (op == ges_pkg::OP_MAC) ? $signed(a_q) * $signed(b_q)
		: $signed(c_q) * $signed(b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_a_q <= 1'b0;
			rd_b_q <= 1'b0;
			rd_x_q <= 1'b0;
			mac_pend_q <= 1'b0;
		end else begin
			rd_a_q <= (op == ges_pkg::OP_RD_A);
			rd_b_q <= (op == ges_pkg::OP_RD_B);
			rd_x_q <= (op == ges_pkg::OP_RD_X);
			mac_pend_q <= (op == ges_pkg::OP_MAC);
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (rd_a_q) a_q <= rdata;
		if (rd_b_q) b_q <= rdata;
		if (rd_x_q) b_q <= xdata;
		prod_q <= ges_pkg::sat32(66'(p / 64'sd65536));
		if (op == ges_pkg::OP_CLR_S) s_q <= '0;
		if (mac_pend_q) s_q <= s_q + 66'($signed(prod_q));
		if (op == ges_pkg::OP_SOL_WR) c_q <= quo;
		else if (op == ges_pkg::OP_NONE && !status.div_busy) c_q <= quo;
	end

	assign status.a_weak = ges_pkg::mag(a_q) <= {17'd0, thr};
	assign status.b_weak = ges_pkg::mag(b_q) <= {17'd0, thr};
	assign a_val = a_q;
endmodule
`default_nettype wire

@@ rtl/core/ges_ctrl.sv @@
// Controller: sequences elimination, singularity check, back substitution and output.
// Depends on ges_pkg.
`default_nettype none
module ges_ctrl #(
	parameter int MaxN = ges_pkg::MaxN
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [4:0]         n_in,
	input  wire logic [15:0]        thr,
	input  wire logic               start,
	input  wire ges_pkg::dp_status_t status,
	input  wire logic [31:0]        sol_val,
	output ges_pkg::dp_cmd_t        cmd,
	output logic                    busy,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              out_index,
	output logic [31:0]             out_sol,
	output logic                    out_sing,
	output logic                    out_last
);
	localparam int NC = MaxN + 1;

	typedef enum logic [19:0] {
		S_IDLE  = 20'h00001,
		S_PIV   = 20'h00002, S_PIVW  = 20'h00004, S_SRCH  = 20'h00008,
		S_SRCHW = 20'h00010, S_SWP   = 20'h00020, S_SWPW  = 20'h00040,
		S_SWPX  = 20'h00080, S_DRD   = 20'h00100, S_DWT   = 20'h00200,
		S_UPD   = 20'h00400, S_UPDW  = 20'h00800, S_UPDX  = 20'h01000,
		S_SING  = 20'h02000, S_SINGW = 20'h04000, S_BRD   = 20'h08000,
		S_BMAC  = 20'h10000, S_BDIV  = 20'h20000, S_BWT   = 20'h40000,
		S_OUT   = 20'h80000
	} state_t;

	state_t st_q;
	logic [5:0] i_q, j_q, k_q, n_q;
	logic [2:0] ph_q;
	logic sing_q;
	logic [31:0] cval_q;

	function automatic logic [12:0] adr(input logic [5:0] r, input logic [5:0] c);
		return 13'(r * NC + c);
	endfunction

	assign busy = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			sing_q <= 1'b0;
			ph_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			out_index <= '0;
			out_sol <= '0;
			out_sing <= 1'b0;
			out_last <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (start) begin
					n_q <= 6'(n_in);
					i_q <= '0;
					ph_q <= '0;
					st_q <= S_PIV;
				end
				S_PIV: begin
					if (i_q + 6'd1 >= n_q) begin
						i_q <= '0; sing_q <= 1'b0; ph_q <= '0; st_q <= S_SING;
					end else begin
						ph_q <= ph_q + 3'd1;
						if (ph_q == 3'd2) begin
							ph_q <= '0;
							if (status.a_weak) begin j_q <= i_q + 6'd1; st_q <= S_SRCH; end
							else begin k_q <= i_q + 6'd1; st_q <= S_DRD; end
						end
					end
				end
				S_SRCH: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						if (!status.a_weak) begin k_q <= '0; st_q <= S_SWP; end
						else if (j_q + 6'd1 >= n_q) begin k_q <= i_q + 6'd1; st_q <= S_DRD; end
						else j_q <= j_q + 6'd1;
					end
				end
				S_SWP: begin
					// Per column: read i into a, read j into b, write both back crossed.
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd5) begin
						ph_q <= '0;
						if (k_q == n_q) begin k_q <= i_q + 6'd1; st_q <= S_DRD; end
						else k_q <= k_q + 6'd1;
					end
				end
				S_DRD: begin
					if (k_q >= n_q) begin i_q <= i_q + 6'd1; st_q <= S_PIV; end
					else begin
						ph_q <= ph_q + 3'd1;
						if (ph_q == 3'd4) begin ph_q <= '0; st_q <= S_DWT; end
					end
				end
				S_DWT: if (!status.div_busy) begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd1) begin ph_q <= '0; j_q <= i_q + 6'd1; st_q <= S_UPD; end
				end
				S_UPD: begin
					// Read row k col j to a, row i col j to b, multiply, write back.
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd5) begin
						ph_q <= '0;
						if (j_q == n_q) begin k_q <= k_q + 6'd1; st_q <= S_DRD; end
						else j_q <= j_q + 6'd1;
					end
				end
				S_SING: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						if (status.a_weak) sing_q <= 1'b1;
						if (i_q + 6'd1 == n_q) begin
							k_q <= n_q - 6'd1; ph_q <= '0; st_q <= S_BRD;
						end else i_q <= i_q + 6'd1;
					end
				end
				S_BRD: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd1) begin ph_q <= '0; j_q <= k_q + 6'd1; st_q <= S_BMAC; end
				end
				S_BMAC: begin
					if (j_q >= n_q) begin ph_q <= '0; st_q <= S_BDIV; end
					else begin
						ph_q <= ph_q + 3'd1;
						if (ph_q == 3'd5) begin ph_q <= '0; j_q <= j_q + 6'd1; end
					end
				end
				S_BDIV: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd4) begin ph_q <= '0; st_q <= S_BWT; end
				end
				S_BWT: if (!status.div_busy) begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						if (k_q == '0) begin k_q <= n_q - 6'd1; st_q <= S_OUT; end
						else begin k_q <= k_q - 6'd1; st_q <= S_BRD; end
					end
				end
				S_OUT: begin
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						if (out_last) st_q <= S_IDLE;
						else k_q <= k_q - 6'd1;
						ph_q <= '0;
					end else if (!out_valid) begin
						ph_q <= ph_q + 3'd1;
						if (ph_q == 3'd1) begin
							out_valid <= 1'b1;
							out_index <= k_q[3:0];
							out_sol <= sol_val;
							out_sing <= sing_q;
							out_last <= (k_q == '0);
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Command decode by state and phase.
	always_comb begin
		cmd.op = ges_pkg::OP_NONE;
		cmd.addr = '0;
		cmd.sidx = '0;
		case (st_q)
			S_PIV: if (ph_q == 3'd0) begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(i_q, i_q); end
			S_SRCH: if (ph_q == 3'd0) begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(j_q, i_q); end
			S_SWP: case (ph_q)
				3'd0: begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(i_q, k_q); end
				3'd1: begin cmd.op = ges_pkg::OP_RD_B; cmd.addr = adr(j_q, k_q); end
				3'd3: begin cmd.op = ges_pkg::OP_WR_A; cmd.addr = adr(j_q, k_q); end
				3'd4: begin cmd.op = ges_pkg::OP_WR_B; cmd.addr = adr(i_q, k_q); end
				default: ;
			endcase
			S_DRD: case (ph_q)
				3'd0: begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(k_q, i_q); end
				3'd1: begin cmd.op = ges_pkg::OP_RD_B; cmd.addr = adr(i_q, i_q); end
				3'd3: begin cmd.op = ges_pkg::OP_DIV; end
				3'd4: begin cmd.op = ges_pkg::OP_WR_ZERO; cmd.addr = adr(k_q, i_q); end
				default: ;
			endcase
			S_UPD: case (ph_q)
				3'd0: begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(k_q, j_q); end
				3'd1: begin cmd.op = ges_pkg::OP_RD_B; cmd.addr = adr(i_q, j_q); end
				3'd4: begin cmd.op = ges_pkg::OP_MUL_SUB; cmd.addr = adr(k_q, j_q); end
				default: ;
			endcase
			S_SING: if (ph_q == 3'd0) begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(i_q, i_q); end
			S_BRD: if (ph_q == 3'd0) cmd.op = ges_pkg::OP_CLR_S;
			S_BMAC: case (ph_q)
				3'd0: begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(k_q, j_q); end
				3'd1: begin cmd.op = ges_pkg::OP_RD_X; cmd.sidx = j_q; end
				3'd3: cmd.op = ges_pkg::OP_NONE;
				3'd4: cmd.op = ges_pkg::OP_MAC;
				default: ;
			endcase
			S_BDIV: case (ph_q)
				3'd0: begin cmd.op = ges_pkg::OP_RD_A; cmd.addr = adr(k_q, n_q); end
				3'd1: begin cmd.op = ges_pkg::OP_RD_B; cmd.addr = adr(k_q, k_q); end
				3'd3: cmd.op = ges_pkg::OP_SUB_DIV;
				default: ;
			endcase
			S_BWT: if (!status.div_busy && ph_q == 3'd1) begin
				cmd.op = ges_pkg::OP_SOL_WR; cmd.sidx = k_q;
			end
			S_OUT: begin cmd.sidx = k_q; end
			default: ;
		endcase
	end

	assign cval_q = '0;
	logic unused;
	assign unused = ^{cval_q, thr};
endmodule
`default_nettype wire

@@ rtl/core/gaussian_elimination_solver.sv @@
// Gaussian elimination solver top level: stream ports, config registers, ctrl + datapath.
// After the last element: elimination per row (pivot test, column swaps, entry updates
// using the serial divide), then back substitution per unknown, then one result per
// unknown from the highest index down, each held until m_axis_tready.
// Throughput: one element per cycle while loading; no input taken during a solve.
// Reset: arst_n clears control state, matrix_size to 2 and small_threshold to 0.
`default_nettype none
module gaussian_elimination_solver #(
	parameter int MaxN = ges_pkg::MaxN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // row[3:0], col[8:4], value[40:9], zero pad
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // index[3:0], solution[35:4], zero pad
	output logic             m_axis_tuser,  // near_singular
	output logic             m_axis_tlast
);
	logic [4:0]  size_q, n_eff;
	logic [15:0] thr_q;
	logic        busy, start, in_fire, in_ok;
	logic [3:0]  row;
	logic [4:0]  col;
	logic [31:0] val, a_val, sol_val, out_sol;
	logic [3:0]  out_index;
	ges_pkg::dp_cmd_t cmd, cmd_mux;
	ges_pkg::dp_status_t status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 5'd2;
			thr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ges_pkg::CfgMatrixSize: size_q <= cfg_data[4:0];
				ges_pkg::CfgThreshold: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_eff = (size_q < 5'd2) ? 5'd2 : ((32'(size_q) > MaxN) ? 5'(MaxN) : size_q);

	assign row = s_axis_tdata[3:0];
	assign col = s_axis_tdata[8:4];
	assign val = s_axis_tdata[40:9];
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign in_ok = in_fire && ({1'b0, row} < n_eff) && (col <= n_eff);
	assign start = in_fire && s_axis_tlast;

	// Load writes use the matrix port while the controller is idle.
	always_comb begin
		cmd_mux = cmd;
		if (!busy) cmd_mux.addr = 13'(row * (MaxN + 1) + col);
	end

	ges_ctrl #(.MaxN(MaxN)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .n_in(n_eff), .thr(thr_q), .start(start),
		.status(status), .sol_val(sol_val), .cmd(cmd), .busy(busy),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_index(out_index),
		.out_sol(out_sol), .out_sing(m_axis_tuser), .out_last(m_axis_tlast)
	);

	ges_datapath #(.MaxN(MaxN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_mux), .load_we(in_ok), .load_data(val),
		.thr(thr_q), .status(status), .a_val(a_val), .sol_val(sol_val)
	);

	assign m_axis_tdata = {4'd0, out_sol, out_index};
	logic unused;
	assign unused = ^{a_val, s_axis_tdata[47:41]};
endmodule
`default_nettype wire

@@ rtl/core/ges_checker.sv @@
// Port-level checker for the Gaussian elimination solver, bound to the top level.
// Depends on gaussian_elimination_solver_macros.svh.
`default_nettype none
`include "gaussian_elimination_solver_macros.svh"
module ges_port_sva (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	`GES_ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input open")
	`GES_ASSERT_IMP(a_last_index0, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[3:0] == 4'd0, "last idx")
	`GES_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "dropped")
endmodule

bind gaussian_elimination_solver ges_port_sva u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
